FILE: rtl/core/fqs_pkg.sv
// ----------------------------------------------------------------------------
// fqs_pkg
// shared types and codes for the fifo queue with search
// ----------------------------------------------------------------------------
`default_nettype none

package fqs_pkg;

  localparam int WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DEQ  = 2'd1,
    KIND_PEEK = 2'd2,
    KIND_SRCH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // search key travelling down the chain
  typedef struct packed {
    logic  vld;
    word_t key;
    logic  hit;
  } pkt_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic shift;
    logic push;
  } ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/fifo_queue_with_search.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_search
// bounded fifo of 32-bit words in a shifting chain of cells, with
// enqueue, dequeue, peek and membership search
// ----------------------------------------------------------------------------
//  channel   ports                                   direction
//  in        in_valid in_stall in_kind in_value      request in
//  out       out_valid out_stall out_status out_data
//            out_found out_count                     result out
//
//  enqueue, dequeue, peek: result registered at acceptance
//  search: the key walks the chain one cell per cycle
//  reset clears count, fsm, output valid and chain valids; words are not reset
//  a stalled result holds the output register and stalls new requests
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_queue_with_search #(
  parameter int DEPTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                in_kind,
  input  wire logic signed [31:0]        in_value,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [1:0]                     out_status,
  output logic signed [31:0]             out_data,
  output logic                           out_found,
  output logic [$clog2(DEPTH + 1)-1:0]   out_count
);
  import fqs_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              hit_r, hit_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  word_t             out_data_r, out_data_nxt;
  logic              out_found_r, out_found_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;

  logic   accept, out_free, launch;
  kind_t  kind;
  ctrl_t  ctrl;
  pkt_t   head_pkt;
  word_t  cell_data [DEPTH];
  pkt_t   cell_pkt  [DEPTH];

  assign kind     = kind_t'(in_kind);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  assign ctrl.push  = accept && (kind == KIND_ENQ) && (count_r < FULL_CNT);
  assign ctrl.shift = accept && (kind == KIND_DEQ) && (count_r != '0);
  assign launch     = accept && (kind == KIND_SRCH);

  assign head_pkt.vld = launch;
  assign head_pkt.key = word_t'(in_value);
  assign head_pkt.hit = 1'b0;

  // chain of slots, head at cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    fqs_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .count     (count_r),
      .push_data (word_t'(in_value)),
      .nbr_data  ((i == DEPTH - 1) ? cell_data[i] : cell_data[(i + 1) % DEPTH]),
      .pkt_in    ((i == 0) ? head_pkt : cell_pkt[(i + DEPTH - 1) % DEPTH]),
      .data      (cell_data[i]),
      .pkt_out   (cell_pkt[i])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    hit_nxt        = hit_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_status_nxt = ST_OK;
          out_data_nxt   = '0;
          out_found_nxt  = 1'b0;
          case (kind)
            KIND_ENQ: begin
              out_valid_nxt = 1'b1;
              if (count_r < FULL_CNT) begin
                count_nxt = count_r + 1'b1;
              end else begin
                out_status_nxt = ST_FULL;
              end
            end
            KIND_DEQ: begin
              out_valid_nxt = 1'b1;
              if (count_r != '0) begin
                out_data_nxt = cell_data[0];
                count_nxt    = count_r - 1'b1;
              end else begin
                out_status_nxt = ST_EMPTY;
              end
            end
            KIND_PEEK: begin
              out_valid_nxt = 1'b1;
              if (count_r != '0) begin
                out_data_nxt = cell_data[0];
              end else begin
                out_status_nxt = ST_EMPTY;
              end
            end
            default: begin
              hit_nxt   = 1'b0;
              state_nxt = S_SCAN;
            end
          endcase
          out_count_nxt = count_nxt;
        end
      end
      S_SCAN: begin
        if (cell_pkt[DEPTH-1].vld) begin
          hit_nxt   = cell_pkt[DEPTH-1].hit;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_data_nxt   = '0;
          out_found_nxt  = hit_r;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    hit_r        <= hit_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_found  = out_found_r;
  assign out_count  = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above depth");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_FULL)) |-> (out_count_r == FULL_CNT))
    else $error("full status with room left");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cell_pkt[DEPTH-1].vld |-> (state_r == S_SCAN))
    else $error("search key left the chain outside a scan");

  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.shift |=> (count_r == $past(count_r) - 1'b1))
    else $error("dequeue did not lower the count");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.push |=> (count_r == $past(count_r) + 1'b1))
    else $error("enqueue did not raise the count");

endmodule

`default_nettype wire

FILE: rtl/core/fqs_cell.sv
// ----------------------------------------------------------------------------
// fqs_cell
// one queue slot: holds a word, shifts toward the head on dequeue, and
// compares a passing search key against its word
// ----------------------------------------------------------------------------
`default_nettype none

module fqs_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fqs_pkg::ctrl_t     ctrl,
  input  wire logic [CNT_W-1:0]   count,
  input  wire fqs_pkg::word_t     push_data,
  input  wire fqs_pkg::word_t     nbr_data,
  input  wire fqs_pkg::pkt_t      pkt_in,
  output fqs_pkg::word_t          data,
  output fqs_pkg::pkt_t           pkt_out
);
  import fqs_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  word_t data_r, data_nxt;
  pkt_t  pkt_r, pkt_nxt;
  logic  held;

  assign held = (MY_IDX < count);

  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift) begin
      data_nxt = nbr_data;
    end else if (ctrl.push && (count == MY_IDX)) begin
      data_nxt = push_data;
    end
  end

  always_comb begin
    pkt_nxt.vld = pkt_in.vld;
    pkt_nxt.key = pkt_in.key;
    pkt_nxt.hit = pkt_in.hit | (pkt_in.vld & held & (data_r == pkt_in.key));
  end

  always_ff @(posedge clk) begin
    data_r      <= data_nxt;
    pkt_r.key   <= pkt_nxt.key;
    pkt_r.hit   <= pkt_nxt.hit;
    if (!rst_n) begin
      pkt_r.vld <= 1'b0;
    end else begin
      pkt_r.vld <= pkt_nxt.vld;
    end
  end

  assign data    = data_r;
  assign pkt_out = pkt_r;

endmodule

`default_nettype wire
